// ----- rtl/assert_macros.svh -----
// assertion macros used by the allocator engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFHA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define FFHA_ASSERT(lbl, prop, msg)
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/ffha_pkg.sv -----
// types, constants and tables of the first-fit heap allocator
`default_nettype none
package ffha_pkg;
	localparam int HEAP_BYTES_MAX    = 65536;
	localparam int ALIGN_BYTES       = 8;
	localparam int HEADER_BYTES      = 16;
	localparam int MAX_FREE_SEGMENTS = 32;
	localparam int MAX_USED_BLOCKS   = 32;
	localparam int HDR_BYTES = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

	localparam int OFS_W  = 17;
	localparam int MIN_W  = 11;
	localparam int REQ_W  = 32;
	localparam int STAT_W = 32;
	localparam int FRAG_W = 7;
	localparam int ACT_W  = 2;
	localparam int CNT_W  = $clog2(MAX_FREE_SEGMENTS + 1);
	localparam int FA_W   = $clog2(MAX_FREE_SEGMENTS);
	localparam int UC_W   = $clog2(MAX_USED_BLOCKS + 1);
	localparam int UA_W   = $clog2(MAX_USED_BLOCKS);

	localparam int HEAP_LO    = 64;
	localparam int HEAP_RESET = 65536;
	localparam int MIN_LO     = 8;
	localparam int MIN_HI     = 1024;
	localparam int MIN_RESET  = 16;

	localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;

	localparam logic CFG_HEAP = 1'b0;
	localparam logic CFG_MIN  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NULL    = 3'd1,
		ST_NOSPACE = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_FULL    = 3'd4
	} status_e;

	typedef struct packed {
		logic [OFS_W-1:0] start;
		logic [OFS_W-1:0] size;
	} seg_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [REQ_W-1:0] req_bytes;
		logic [OFS_W-1:0] block_offset;
	} item_t;

	typedef struct packed {
		status_e           status;
		logic [OFS_W-1:0]  user_offset;
		logic [OFS_W-1:0]  heap_total;
		logic [OFS_W-1:0]  used_bytes;
		logic [OFS_W-1:0]  peak_used_bytes;
		logic [CNT_W-1:0]  free_segments;
		logic [STAT_W-1:0] alloc_total;
		logic [STAT_W-1:0] free_total;
		logic [STAT_W-1:0] fail_total;
		logic [FRAG_W-1:0] fragmentation_pct;
	} res_t;

	// (n-1)*100/n
	function automatic logic [FRAG_W-1:0] frag_pct(input logic [CNT_W-1:0] n);
		logic [FRAG_W-1:0] r;
		case (n)
			6'd2:  r = 7'd50;
			6'd3:  r = 7'd66;
			6'd4:  r = 7'd75;
			6'd5:  r = 7'd80;
			6'd6:  r = 7'd83;
			6'd7:  r = 7'd85;
			6'd8:  r = 7'd87;
			6'd9:  r = 7'd88;
			6'd10: r = 7'd90;
			6'd11: r = 7'd90;
			6'd12: r = 7'd91;
			6'd13: r = 7'd92;
			6'd14: r = 7'd92;
			6'd15: r = 7'd93;
			6'd16: r = 7'd93;
			6'd17: r = 7'd94;
			6'd18: r = 7'd94;
			6'd19: r = 7'd94;
			6'd20: r = 7'd95;
			6'd21: r = 7'd95;
			6'd22: r = 7'd95;
			6'd23: r = 7'd95;
			6'd24: r = 7'd95;
			6'd25: r = 7'd96;
			6'd26: r = 7'd96;
			6'd27: r = 7'd96;
			6'd28: r = 7'd96;
			6'd29: r = 7'd96;
			6'd30: r = 7'd96;
			6'd31: r = 7'd96;
			6'd32: r = 7'd96;
			default: r = 7'd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/ffha_ctrl.sv -----
// allocator engine: segment and block tables in memories, sequencer, statistics
`default_nettype none
`include "assert_macros.svh"
module ffha_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_en,
	input  wire logic                      cfg_index,
	input  wire logic [ffha_pkg::OFS_W-1:0] cfg_data,
	input  wire logic                      start,
	input  wire ffha_pkg::item_t           item,
	output logic                           ready,
	output logic                           done,
	input  wire logic                      ack,
	output ffha_pkg::res_t                 res
);
	import ffha_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_A_RD, S_A_CK, S_A_FIN, S_DN_RD, S_DN_WR, S_U_RD, S_U_CK,
		S_P_RD, S_P_CK, S_P_DEC, S_UP_RD, S_UP_WR, S_F_FIN, S_DONE
	} state_t;

	state_t                state_q;
	logic [OFS_W-1:0]      heap_q, avail_q, peak_q;
	logic [MIN_W-1:0]      min_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [FA_W-1:0]       k_q;
	logic [MAX_USED_BLOCKS-1:0] valid_q;
	logic [STAT_W-1:0]     alloc_q, free_q, fail_q;
	logic [OFS_W-1:0]      fin_q, blk_q, bsz_q, off_q, uoff_q;
	logic [UA_W-1:0]       slot_q;
	logic                  is_free_q, have_cur_q;
	seg_t                  prev_q, cur_q;
	status_e               status_q;

	// tables
	seg_t fmem [MAX_FREE_SEGMENTS];
	seg_t umem [MAX_USED_BLOCKS];
	seg_t f_rd_q, u_rd_q;
	logic             f_we, u_we;
	logic [FA_W-1:0]  f_waddr, f_raddr;
	logic [UA_W-1:0]  u_waddr, u_raddr;
	seg_t             f_wdata, u_wdata;

	always_ff @(posedge clk) begin
		if (f_we)
			fmem[f_waddr] <= f_wdata;
		f_rd_q <= fmem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (u_we)
			umem[u_waddr] <= u_wdata;
		u_rd_q <= umem[u_raddr];
	end

	// request sizing
	logic [REQ_W:0]   fin_sum, fin_al, fin;
	logic             nospace, slot_found;
	logic [UA_W-1:0]  free_slot;

	always_comb begin
		fin_sum = {1'b0, item.req_bytes} + (REQ_W+1)'(HDR_BYTES + ALIGN_BYTES - 1);
		fin_al  = (fin_sum / (REQ_W+1)'(ALIGN_BYTES)) * (REQ_W+1)'(ALIGN_BYTES);
		fin     = (fin_al < (REQ_W+1)'(min_q)) ? (REQ_W+1)'(min_q) : fin_al;
		nospace = fin > (REQ_W+1)'(avail_q);
		slot_found = 1'b0;
		free_slot  = '0;
		for (int i = MAX_USED_BLOCKS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				slot_found = 1'b1;
				free_slot  = UA_W'(i);
			end
		end
	end

	// compares on the registered table reads
	logic             a_hit, a_split, u_hit, p_gt, mp, mn, up_done, dn_last;
	logic [OFS_W-1:0] a_rem;
	logic [OFS_W:0]   avail_sum;
	logic [OFS_W-1:0] avail_sub, used_new;

	always_comb begin
		a_hit   = f_rd_q.size >= fin_q;
		a_rem   = f_rd_q.size - fin_q;
		a_split = a_rem >= OFS_W'(min_q);
		u_hit   = valid_q[idx_q[UA_W-1:0]] &&
			(({1'b0, u_rd_q.start} + (OFS_W+1)'(HDR_BYTES)) == {1'b0, off_q});
		p_gt    = f_rd_q.start > blk_q;
		mp      = (idx_q != '0) &&
			(({1'b0, prev_q.start} + {1'b0, prev_q.size}) == {1'b0, blk_q});
		mn      = have_cur_q && (({1'b0, blk_q} + {1'b0, bsz_q}) == {1'b0, cur_q.start});
		up_done = {1'b0, k_q} == idx_q;
		dn_last = (idx_q + CNT_W'(1)) >= count_q;
		avail_sub = (bsz_q > avail_q) ? '0 : avail_q - bsz_q;
		used_new  = heap_q - avail_sub;
		avail_sum = {1'b0, avail_q} + {1'b0, bsz_q};
	end

	// memory ports
	always_comb begin
		f_we    = 1'b0;
		f_waddr = idx_q[FA_W-1:0];
		f_raddr = idx_q[FA_W-1:0];
		f_wdata = f_rd_q;
		u_we    = 1'b0;
		u_waddr = slot_q;
		u_raddr = idx_q[UA_W-1:0];
		u_wdata = '{start: blk_q, size: bsz_q};
		unique case (state_q)
			S_INIT: begin
				f_we    = 1'b1;
				f_waddr = '0;
				f_wdata = '{start: '0, size: heap_q};
			end
			S_A_CK: begin
				if (a_hit && a_split) begin
					f_we    = 1'b1;
					f_wdata = '{start: f_rd_q.start + fin_q, size: a_rem};
				end
			end
			S_A_FIN: u_we = 1'b1;
			S_DN_RD: f_raddr = FA_W'(idx_q + CNT_W'(1));
			S_DN_WR: f_we = 1'b1;
			S_P_DEC: begin
				if (mp && mn) begin
					f_we    = 1'b1;
					f_waddr = FA_W'(idx_q - CNT_W'(1));
					f_wdata = '{start: prev_q.start, size: prev_q.size + bsz_q + cur_q.size};
				end else if (mp) begin
					f_we    = 1'b1;
					f_waddr = FA_W'(idx_q - CNT_W'(1));
					f_wdata = '{start: prev_q.start, size: prev_q.size + bsz_q};
				end else if (mn) begin
					f_we    = 1'b1;
					f_wdata = '{start: blk_q, size: cur_q.size + bsz_q};
				end
			end
			S_UP_RD: begin
				if (up_done) begin
					f_we    = 1'b1;
					f_wdata = '{start: blk_q, size: bsz_q};
				end else begin
					f_raddr = k_q - FA_W'(1);
				end
			end
			S_UP_WR: begin
				f_we    = 1'b1;
				f_waddr = k_q;
			end
			default: ;
		endcase
	end

	logic [OFS_W-1:0] heap_cl;
	logic [MIN_W-1:0] min_cl;

	always_comb begin
		if (cfg_data < OFS_W'(HEAP_LO))
			heap_cl = OFS_W'(HEAP_LO);
		else if (cfg_data > OFS_W'(HEAP_BYTES_MAX))
			heap_cl = OFS_W'(HEAP_BYTES_MAX);
		else
			heap_cl = cfg_data;
		if (cfg_data[MIN_W-1:0] < MIN_W'(MIN_LO))
			min_cl = MIN_W'(MIN_LO);
		else if (cfg_data[MIN_W-1:0] > MIN_W'(MIN_HI))
			min_cl = MIN_W'(MIN_HI);
		else
			min_cl = cfg_data[MIN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			heap_q     <= OFS_W'(HEAP_RESET);
			avail_q    <= OFS_W'(HEAP_RESET);
			min_q      <= MIN_W'(MIN_RESET);
			peak_q     <= '0;
			count_q    <= CNT_W'(1);
			idx_q      <= '0;
			k_q        <= '0;
			valid_q    <= '0;
			alloc_q    <= '0;
			free_q     <= '0;
			fail_q     <= '0;
			fin_q      <= '0;
			blk_q      <= '0;
			bsz_q      <= '0;
			off_q      <= '0;
			uoff_q     <= '0;
			slot_q     <= '0;
			is_free_q  <= 1'b0;
			have_cur_q <= 1'b0;
			prev_q     <= '0;
			cur_q      <= '0;
			status_q   <= ST_OK;
		end else if (cfg_en) begin
			if (cfg_index == CFG_HEAP) begin
				heap_q  <= heap_cl;
				avail_q <= heap_cl;
				count_q <= CNT_W'(1);
				valid_q <= '0;
				state_q <= S_INIT;
			end else begin
				min_q <= min_cl;
			end
		end else begin
			unique case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (start) begin
						uoff_q   <= '0;
						status_q <= ST_OK;
						idx_q    <= '0;
						off_q    <= item.block_offset;
						unique case (item.action)
							ACT_ALLOC: begin
								is_free_q <= 1'b0;
								fin_q     <= fin[OFS_W-1:0];
								slot_q    <= free_slot;
								if (item.req_bytes == '0) begin
									status_q <= ST_NULL;
									state_q  <= S_DONE;
								end else if (nospace) begin
									fail_q   <= fail_q + STAT_W'(1);
									status_q <= ST_NOSPACE;
									state_q  <= S_DONE;
								end else if (!slot_found) begin
									fail_q   <= fail_q + STAT_W'(1);
									status_q <= ST_FULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_A_RD;
								end
							end
							ACT_FREE: begin
								is_free_q <= 1'b1;
								if (item.block_offset == '0) begin
									status_q <= ST_NULL;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_U_RD;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_A_RD: begin
					if (idx_q == count_q) begin
						fail_q   <= fail_q + STAT_W'(1);
						status_q <= ST_NOSPACE;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_A_CK;
					end
				end
				S_A_CK: begin
					if (a_hit) begin
						blk_q <= f_rd_q.start;
						if (a_split) begin
							bsz_q   <= fin_q;
							state_q <= S_A_FIN;
						end else begin
							bsz_q   <= f_rd_q.size;
							state_q <= S_DN_RD;
						end
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_A_RD;
					end
				end
				S_A_FIN: begin
					valid_q[slot_q] <= 1'b1;
					avail_q <= avail_sub;
					if (used_new > peak_q)
						peak_q <= used_new;
					alloc_q  <= alloc_q + STAT_W'(1);
					uoff_q   <= blk_q + OFS_W'(HDR_BYTES);
					state_q  <= S_DONE;
				end
				// close the gap left by a removed segment
				S_DN_RD: begin
					if (dn_last) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= is_free_q ? S_F_FIN : S_A_FIN;
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					idx_q   <= idx_q + CNT_W'(1);
					state_q <= S_DN_RD;
				end
				S_U_RD: begin
					if (idx_q == UC_W'(MAX_USED_BLOCKS)) begin
						status_q <= ST_UNKNOWN;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_U_CK;
					end
				end
				S_U_CK: begin
					if (u_hit) begin
						blk_q   <= u_rd_q.start;
						bsz_q   <= u_rd_q.size;
						slot_q  <= idx_q[UA_W-1:0];
						idx_q   <= '0;
						state_q <= S_P_RD;
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_U_RD;
					end
				end
				S_P_RD: begin
					if (idx_q == count_q) begin
						have_cur_q <= 1'b0;
						state_q    <= S_P_DEC;
					end else begin
						state_q <= S_P_CK;
					end
				end
				S_P_CK: begin
					if (p_gt) begin
						cur_q      <= f_rd_q;
						have_cur_q <= 1'b1;
						state_q    <= S_P_DEC;
					end else begin
						prev_q  <= f_rd_q;
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_P_RD;
					end
				end
				S_P_DEC: begin
					if (mp && mn) begin
						state_q <= S_DN_RD;
					end else if (mp || mn) begin
						state_q <= S_F_FIN;
					end else if (count_q >= CNT_W'(MAX_FREE_SEGMENTS)) begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						k_q     <= count_q[FA_W-1:0];
						state_q <= S_UP_RD;
					end
				end
				// open a gap at the insert position, top entry first
				S_UP_RD: begin
					if (up_done) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_F_FIN;
					end else begin
						state_q <= S_UP_WR;
					end
				end
				S_UP_WR: begin
					k_q     <= k_q - FA_W'(1);
					state_q <= S_UP_RD;
				end
				S_F_FIN: begin
					valid_q[slot_q] <= 1'b0;
					avail_q <= (avail_sum > {1'b0, heap_q}) ? heap_q : avail_sum[OFS_W-1:0];
					free_q  <= free_q + STAT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ack)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ready = state_q == S_IDLE;
	assign done  = state_q == S_DONE;

	always_comb begin
		res.status            = status_q;
		res.user_offset       = uoff_q;
		res.heap_total        = heap_q;
		res.used_bytes        = heap_q - avail_q;
		res.peak_used_bytes   = peak_q;
		res.free_segments     = count_q;
		res.alloc_total       = alloc_q;
		res.free_total        = free_q;
		res.fail_total        = fail_q;
		res.fragmentation_pct = frag_pct(count_q);
	end

	`FFHA_ASSERT(a_count_max, count_q <= CNT_W'(MAX_FREE_SEGMENTS), "free table overflow")
	`FFHA_ASSERT(a_avail_max, avail_q <= heap_q, "available bytes exceed heap")
	`FFHA_ASSERT_IMP(a_slot_free, state_q == S_A_FIN, !valid_q[slot_q], "slot already in use")
	`FFHA_ASSERT_IMP(a_ins_room, state_q == S_UP_RD, count_q < CNT_W'(MAX_FREE_SEGMENTS), "insert into full table")
endmodule
`default_nettype wire

// ----- rtl/first_fit_heap_allocator.sv -----
// first-fit heap allocator: stream ports, result register and engine
// Usage:
//  cfg_en/cfg_index/cfg_data write heap_bytes (index 0) or min_block_bytes (index 1)
//  while the block is idle; writing heap_bytes reinitialises the tables to one
//  free segment, counters and peak are kept.
//  s_* carries one request per transaction: tuser holds the action, tdata the
//  request size and the block offset. m_* returns exactly one result per request:
//  tuser holds the status, tdata the offset and all statistics.
//  Requests are processed one at a time. A query or an undefined action goes
//  straight to the result; an allocate scans the free segments in order and,
//  when a segment is used up, moves the later entries down; a free scans the
//  used table, then the free segments for the insert position, and moves entries
//  to close or open a gap where needed. Each table memory has a single read port.
//  After reset and after each heap_bytes write the engine writes the initial
//  free segment, with s_tready low, before it goes to idle.
//  A result waits in the output register while m_tready is low; the next request
//  is still taken and processed, and the engine holds its result until the
//  register frees up.
`default_nettype none
module first_fit_heap_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_en,
	input  wire logic          cfg_index,
	input  wire logic [16:0]   cfg_data,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [55:0]   s_tdata,  // request_size, block_offset
	input  wire logic [1:0]    s_tuser,  // action
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [183:0]       m_tdata,  // user_offset, heap_total, used_bytes,
	                                     // peak_used_bytes, free_segments, alloc_total,
	                                     // free_total, fail_total, fragmentation_pct
	output logic [2:0]         m_tuser   // status
);
	import ffha_pkg::*;

	localparam int OUT_BITS = $bits(res_t) - 3;

	item_t item;
	res_t  res;
	logic  eng_ready, eng_done, load;
	logic  out_v_q;
	logic [OUT_BITS-1:0] out_data_q;
	logic [2:0]          out_user_q;

	always_comb begin
		item.action       = s_tuser;
		item.req_bytes    = s_tdata[REQ_W-1:0];
		item.block_offset = s_tdata[REQ_W+OFS_W-1:REQ_W];
	end

	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (s_tvalid && eng_ready),
		.item      (item),
		.ready     (eng_ready),
		.done      (eng_done),
		.ack       (load),
		.res       (res)
	);

	assign s_tready = eng_ready;
	assign load     = eng_done && (!out_v_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q    <= 1'b0;
			out_data_q <= '0;
			out_user_q <= '0;
		end else begin
			if (load) begin
				out_v_q    <= 1'b1;
				out_user_q <= res.status;
				out_data_q <= {res.fragmentation_pct, res.fail_total, res.free_total,
					res.alloc_total, res.free_segments, res.peak_used_bytes,
					res.used_bytes, res.heap_total, res.user_offset};
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_user_q;
	assign m_tdata  = {(184 - OUT_BITS)'(0), out_data_q};
endmodule
`default_nettype wire

// ----- sim/tb_first_fit_heap_allocator.sv -----
// self-checking testbench for the first-fit heap allocator
`timescale 1ns / 1ps
`default_nettype none
module tb_first_fit_heap_allocator;
	import ffha_pkg::*;

	logic          clk;
	logic          arst_n;
	logic          cfg_en;
	logic          cfg_index;
	logic [16:0]   cfg_data;
	logic          s_tvalid;
	logic          s_tready;
	logic [55:0]   s_tdata;  // request_size, block_offset
	logic [1:0]    s_tuser;  // action
	logic          m_tvalid;
	logic          m_tready;
	logic [183:0]  m_tdata;  // user_offset, heap_total, used_bytes, peak_used_bytes,
	                         // free_segments, alloc_total, free_total, fail_total,
	                         // fragmentation_pct
	logic [2:0]    m_tuser;  // status

	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;
	localparam logic [ACT_W-1:0] ACT_UNDEF = 2'd3;
	localparam int DRAIN_CYCLES = 250;

	first_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// allocator shadow state
	longint heap_sz, min_blk, avail, peak;
	longint seg_start [MAX_FREE_SEGMENTS];
	longint seg_size [MAX_FREE_SEGMENTS];
	int seg_cnt;
	longint blk_start [MAX_USED_BLOCKS];
	longint blk_size [MAX_USED_BLOCKS];
	bit blk_live [MAX_USED_BLOCKS];
	logic [31:0] n_alloc, n_free, n_fail;

	res_t result_q [$];
	logic [OFS_W-1:0] live_offsets [$];
	int errors;
	int n_checked;
	int idle_pct, stall_pct;
	int cnt_ok, cnt_nospace, cnt_full, cnt_unknown, cnt_null;

	function automatic void reinit_tables();
		seg_start[0] = 0;
		seg_size[0] = heap_sz;
		seg_cnt = 1;
		for (int i = 0; i < MAX_USED_BLOCKS; i++) blk_live[i] = 1'b0;
		avail = heap_sz;
	endfunction

	function automatic void drop_seg(int i);
		for (int k = i; k + 1 < seg_cnt; k++) begin
			seg_start[k] = seg_start[k + 1];
			seg_size[k] = seg_size[k + 1];
		end
		seg_cnt--;
	endfunction

	function automatic status_e heap_alloc(logic [31:0] req, output longint uoff);
		longint fin, bsz, b;
		int slot, i;
		uoff = 0;
		if (req == 0) return ST_NULL;
		fin = ((longint'(req) + HDR_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
		if (fin < min_blk) fin = min_blk;
		if (fin > avail) begin
			n_fail++;
			return ST_NOSPACE;
		end
		for (slot = 0; slot < MAX_USED_BLOCKS; slot++)
			if (!blk_live[slot]) break;
		if (slot >= MAX_USED_BLOCKS) begin
			n_fail++;
			return ST_FULL;
		end
		for (i = 0; i < seg_cnt; i++)
			if (seg_size[i] >= fin) break;
		if (i >= seg_cnt) begin
			n_fail++;
			return ST_NOSPACE;
		end
		b = seg_start[i];
		if (seg_size[i] - fin >= min_blk) begin
			bsz = fin;
			seg_start[i] += fin;
			seg_size[i] -= fin;
		end else begin
			bsz = seg_size[i];
			drop_seg(i);
		end
		blk_start[slot] = b;
		blk_size[slot] = bsz;
		blk_live[slot] = 1'b1;
		avail = bsz > avail ? 0 : avail - bsz;
		if (heap_sz - avail > peak) peak = heap_sz - avail;
		n_alloc++;
		uoff = b + HDR_BYTES;
		return ST_OK;
	endfunction

	function automatic status_e heap_free(logic [OFS_W-1:0] off);
		int s, pos;
		longint b, sz;
		bit mp, mn;
		if (off == 0) return ST_NULL;
		for (s = 0; s < MAX_USED_BLOCKS; s++)
			if (blk_live[s] && blk_start[s] + HDR_BYTES == off) break;
		if (s >= MAX_USED_BLOCKS) return ST_UNKNOWN;
		b = blk_start[s];
		sz = blk_size[s];
		for (pos = 0; pos < seg_cnt; pos++)
			if (seg_start[pos] > b) break;
		mp = pos > 0 && seg_start[pos - 1] + seg_size[pos - 1] == b;
		mn = pos < seg_cnt && b + sz == seg_start[pos];
		if (mp && mn) begin
			seg_size[pos - 1] += sz + seg_size[pos];
			drop_seg(pos);
		end else if (mp) begin
			seg_size[pos - 1] += sz;
		end else if (mn) begin
			seg_start[pos] = b;
			seg_size[pos] += sz;
		end else begin
			if (seg_cnt >= MAX_FREE_SEGMENTS) return ST_FULL;
			for (int k = seg_cnt; k > pos; k--) begin
				seg_start[k] = seg_start[k - 1];
				seg_size[k] = seg_size[k - 1];
			end
			seg_start[pos] = b;
			seg_size[pos] = sz;
			seg_cnt++;
		end
		blk_live[s] = 1'b0;
		avail += sz;
		if (avail > heap_sz) avail = heap_sz;
		n_free++;
		return ST_OK;
	endfunction

	function automatic res_t predict_result(item_t it);
		res_t r;
		longint uoff;
		uoff = 0;
		r.status = ST_OK;
		if (it.action == ACT_ALLOC) r.status = heap_alloc(it.req_bytes, uoff);
		else if (it.action == ACT_FREE) r.status = heap_free(it.block_offset);
		r.user_offset = uoff[OFS_W-1:0];
		r.heap_total = heap_sz[OFS_W-1:0];
		r.used_bytes = OFS_W'(heap_sz - avail);
		r.peak_used_bytes = peak[OFS_W-1:0];
		r.free_segments = CNT_W'(seg_cnt);
		r.alloc_total = n_alloc;
		r.free_total = n_free;
		r.fail_total = n_fail;
		r.fragmentation_pct = FRAG_W'(seg_cnt > 1 ? ((seg_cnt - 1) * 100) / seg_cnt : 0);
		return r;
	endfunction

	// one request transaction; predicts at acceptance
	task automatic send_request(input logic [1:0] act, input logic [31:0] req,
			input logic [OFS_W-1:0] off);
		item_t it;
		res_t r;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		it.action = act;
		it.req_bytes = req;
		it.block_offset = off;
		s_tuser <= act;
		s_tdata <= {7'd0, off, req};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		r = predict_result(it);
		result_q.push_back(r);
		if (act == ACT_ALLOC && r.status == ST_OK) live_offsets.push_back(r.user_offset);
		if (act == ACT_FREE && r.status == ST_OK)
			foreach (live_offsets[i])
				if (live_offsets[i] == off) begin
					live_offsets.delete(i);
					break;
				end
		case (r.status)
			ST_OK:      cnt_ok++;
			ST_NULL:    cnt_null++;
			ST_NOSPACE: cnt_nospace++;
			ST_UNKNOWN: cnt_unknown++;
			default:    cnt_full++;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (result_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [16:0] val);
		longint v;
		wait_idle();
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_en <= 1'b0;
		if (idx == CFG_HEAP) begin
			v = val;
			heap_sz = v < HEAP_LO ? HEAP_LO : (v > HEAP_BYTES_MAX ? HEAP_BYTES_MAX : v);
			reinit_tables();
			live_offsets.delete();
		end else begin
			v = val[10:0];
			min_blk = v < MIN_LO ? MIN_LO : (v > MIN_HI ? MIN_HI : v);
		end
	endtask

	task automatic free_live(input int idx);
		send_request(ACT_FREE, $urandom, live_offsets[idx]);
	endtask

	always @(negedge clk)
		m_tready <= $urandom_range(99) >= stall_pct;

	always @(posedge clk) begin
		res_t e;
		logic [OFS_W-1:0] f_uoff, f_heap, f_used, f_peak;
		logic [CNT_W-1:0] f_segs;
		logic [31:0] f_alloc, f_free, f_fail;
		logic [FRAG_W-1:0] f_frag;
		if (arst_n && m_tvalid && m_tready) begin
			{f_frag, f_fail, f_free, f_alloc, f_segs, f_peak, f_used, f_heap, f_uoff} =
				m_tdata[176:0];
			if (result_q.size() == 0) begin
				$error("result transaction with no request outstanding");
				errors++;
			end else begin
				e = result_q.pop_front();
				n_checked++;
				if (m_tuser != e.status) begin
					$error("status: expected %0d, got %0d", e.status, m_tuser); errors++;
				end
				if (f_uoff != e.user_offset) begin
					$error("user_offset: expected %0d, got %0d", e.user_offset, f_uoff); errors++;
				end
				if (f_heap != e.heap_total) begin
					$error("heap_total: expected %0d, got %0d", e.heap_total, f_heap); errors++;
				end
				if (f_used != e.used_bytes) begin
					$error("used_bytes: expected %0d, got %0d", e.used_bytes, f_used); errors++;
				end
				if (f_peak != e.peak_used_bytes) begin
					$error("peak_used_bytes: expected %0d, got %0d", e.peak_used_bytes, f_peak);
					errors++;
				end
				if (f_segs != e.free_segments) begin
					$error("free_segments: expected %0d, got %0d", e.free_segments, f_segs);
					errors++;
				end
				if (f_alloc != e.alloc_total) begin
					$error("alloc_total: expected %0d, got %0d", e.alloc_total, f_alloc); errors++;
				end
				if (f_free != e.free_total) begin
					$error("free_total: expected %0d, got %0d", e.free_total, f_free); errors++;
				end
				if (f_fail != e.fail_total) begin
					$error("fail_total: expected %0d, got %0d", e.fail_total, f_fail); errors++;
				end
				if (f_frag != e.fragmentation_pct) begin
					$error("fragmentation_pct: expected %0d, got %0d", e.fragmentation_pct,
						f_frag);
					errors++;
				end
			end
		end
	end

	// queries, null cases, limits, merging on both sides
	task automatic test_directed();
		send_request(ACT_QUERY, 32'd0, '0);
		send_request(ACT_UNDEF, 32'hFFFF_FFFF, 17'h1FFFF);
		send_request(ACT_ALLOC, 32'd0, '0);
		send_request(ACT_ALLOC, 32'hFFFF_FFFF, '0);
		send_request(ACT_FREE, 32'd0, '0);
		send_request(ACT_FREE, 32'd0, 17'h10000);
		// whole heap in one block, then back
		send_request(ACT_ALLOC, 32'(heap_sz - HDR_BYTES), '0);
		send_request(ACT_ALLOC, 32'd1, '0);
		free_live(0);
		send_request(ACT_ALLOC, 32'd1, '0);
		send_request(ACT_ALLOC, 32'd40, '0);
		send_request(ACT_ALLOC, 32'd7, '0);
		send_request(ACT_ALLOC, 32'd100, '0);
		free_live(1);
		free_live(0);
		free_live(1);
		free_live(0);
		send_request(ACT_FREE, 32'd0, 17'd16);
		send_request(ACT_QUERY, 32'd0, '0);
	endtask

	// exhaust the used-block table, then release it in scattered order
	task automatic test_table_full();
		write_reg(CFG_MIN, 17'd8);
		for (int i = 0; i < MAX_USED_BLOCKS + 2; i++) send_request(ACT_ALLOC, 32'd1, '0);
		for (int i = 0; i < MAX_USED_BLOCKS; i += 2) free_live(i / 2);
		while (live_offsets.size() != 0) free_live($urandom_range(live_offsets.size() - 1));
	endtask

	task automatic test_random(input int n_items);
		int k;
		logic [31:0] req;
		for (int i = 0; i < n_items; i++) begin
			k = $urandom_range(99);
			if (i == n_items / 2) wait_idle();
			if (k < 48) begin
				case ($urandom_range(9))
					0:       req = $urandom;
					1:       req = $urandom_range(32'(heap_sz));
					2:       req = 32'd0;
					3, 4:    req = $urandom_range(1024);
					default: req = $urandom_range(1, 64);
				endcase
				send_request(ACT_ALLOC, req, 17'($urandom));
			end else if (k < 85 && live_offsets.size() != 0) begin
				free_live($urandom_range(live_offsets.size() - 1));
			end else if (k < 93) begin
				send_request(ACT_FREE, $urandom, $urandom_range(1) ? '0 : 17'($urandom));
			end else begin
				send_request($urandom_range(1) ? ACT_QUERY : ACT_UNDEF, $urandom,
					17'($urandom));
			end
		end
	endtask

	task automatic test_configs();
		write_reg(CFG_HEAP, 17'd0);
		write_reg(CFG_MIN, 17'h1FFFF);
		test_random(250);
		write_reg(CFG_HEAP, 17'h1FFFF);
		write_reg(CFG_MIN, 17'd0);
		test_random(250);
		write_reg(CFG_HEAP, 17'd64);
		write_reg(CFG_MIN, 17'd1024);
		test_random(100);
		write_reg(CFG_HEAP, 17'd4096);
		write_reg(CFG_MIN, 17'd24);
	endtask

	initial begin
		#200ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		errors = 0; n_checked = 0;
		cnt_ok = 0; cnt_nospace = 0; cnt_full = 0; cnt_unknown = 0; cnt_null = 0;
		idle_pct = 0; stall_pct = 0;
		arst_n = 1'b0;
		cfg_en = 1'b0; cfg_index = 1'b0; cfg_data = '0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		m_tready = 1'b1;
		heap_sz = HEAP_RESET; min_blk = MIN_RESET; peak = 0;
		n_alloc = 0; n_free = 0; n_fail = 0;
		reinit_tables();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_table_full();
		test_random(250);
		idle_pct = 58; stall_pct = 0;
		test_random(350);
		test_configs();
		idle_pct = 0; stall_pct = 58;
		test_random(350);
		idle_pct = 37; stall_pct = 37;
		write_reg(CFG_HEAP, 17'd65536);
		write_reg(CFG_MIN, 17'd16);
		test_random(300);
		wait_idle();

		$display("checked %0d results: %0d ok, %0d null, %0d no space, %0d unknown, %0d full",
			n_checked, cnt_ok, cnt_null, cnt_nospace, cnt_unknown, cnt_full);
		$display("several heap and minimum block settings, random idling on both sides");
		if (errors == 0 && result_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
